FILE: sv/r2fft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared widths, command codes and the twiddle table of the radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int LOG2_MAX_POINTS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int TWIDDLE_BITS    = 16;
  localparam int BUF_BITS        = SAMPLE_BITS + LOG2_MAX_POINTS;
  localparam int MAX_POINTS      = 1 << LOG2_MAX_POINTS;
  localparam int ROM_DEPTH       = MAX_POINTS / 2;
  localparam int IDX_BITS        = LOG2_MAX_POINTS;
  localparam int LG_BITS         = 4;
  localparam int OUT_BITS        = 26;

  // angle step of one table entry
  localparam real TW_STEP = 2.0 * 3.14159265358979323846 / real'(MAX_POINTS);

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_RUN  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_INV  = 1'b1;

  typedef logic signed [BUF_BITS-1:0]     buf_t;
  typedef logic signed [TWIDDLE_BITS-1:0] tw_t;
  typedef logic [2*TWIDDLE_BITS-1:0]      tw_rom_t [ROM_DEPTH];

  // twiddle pair (cos, -sin) of angle 2*pi*n/MAX_POINTS, Q1.15, +1.0 saturated
  function automatic logic [2*TWIDDLE_BITS-1:0] twiddle(input logic [IDX_BITS-2:0] n);
    real    a;
    real    c;
    real    s;
    integer ci;
    integer si;
    a  = TW_STEP * real'(n);
    c  = $cos(a) * real'(1 << (TWIDDLE_BITS - 1));
    s  = -$sin(a) * real'(1 << (TWIDDLE_BITS - 1));
    ci = (c >= 0.0) ? integer'($floor(c + 0.5)) : -integer'($floor(-c + 0.5));
    si = (s >= 0.0) ? integer'($floor(s + 0.5)) : -integer'($floor(-s + 0.5));
    if (ci > (1 << (TWIDDLE_BITS - 1)) - 1) ci = (1 << (TWIDDLE_BITS - 1)) - 1;
    if (si > (1 << (TWIDDLE_BITS - 1)) - 1) si = (1 << (TWIDDLE_BITS - 1)) - 1;
    twiddle = {ci[TWIDDLE_BITS-1:0], si[TWIDDLE_BITS-1:0]};
  endfunction

  // whole twiddle table, evaluated at elaboration
  function automatic tw_rom_t build_twiddle_rom();
    tw_rom_t rom;
    for (int n = 0; n < ROM_DEPTH; n++)
      rom[n] = twiddle(n[IDX_BITS-2:0]);
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_twiddle_rom();

  // saturate a wide sum to the store width
  function automatic buf_t sat_buf(input logic signed [BUF_BITS+1:0] v);
    if (v > $signed({{2{1'b0}}, 1'b0, {(BUF_BITS-1){1'b1}}}))
      sat_buf = {1'b0, {(BUF_BITS-1){1'b1}}};
    else if (v < $signed({{2{1'b1}}, 1'b1, {(BUF_BITS-1){1'b0}}}))
      sat_buf = {1'b1, {(BUF_BITS-1){1'b0}}};
    else
      sat_buf = v[BUF_BITS-1:0];
  endfunction

endpackage

FILE: sv/r2fft_bfly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_bfly
// Shared butterfly unit: registered complex twiddle product, then sum and
// difference with optional halving and saturation.
// ----------------------------------------------------------------------------
module r2fft_bfly (
  input  logic                 clk,
  input  logic                 inv,
  input  logic                 bypass,
  input  r2fft_pkg::buf_t      br,
  input  r2fft_pkg::buf_t      bi,
  input  r2fft_pkg::tw_t       wr,
  input  r2fft_pkg::tw_t       wi,
  input  r2fft_pkg::buf_t      ar,
  input  r2fft_pkg::buf_t      ai,
  output r2fft_pkg::buf_t      sr,
  output r2fft_pkg::buf_t      si,
  output r2fft_pkg::buf_t      dr,
  output r2fft_pkg::buf_t      di
);
  import r2fft_pkg::*;

  localparam int PW = BUF_BITS + TWIDDLE_BITS;

  logic signed [PW-1:0]  p_rr, p_ii, p_ri, p_ir;
  logic signed [PW:0]    pr, pi;
  logic signed [PW:0]    rnd;
  logic signed [PW:0]    tr_w, ti_w;
  // rotated value can reach sqrt(2) times full scale
  logic signed [BUF_BITS:0]   tr, ti;
  logic signed [BUF_BITS+1:0] s_r, s_i, d_r, d_i;

  // products registered before the adders
  always_ff @(posedge clk) begin
    p_rr <= br * wr;
    p_ii <= bi * wi;
    p_ri <= br * wi;
    p_ir <= bi * wr;
  end

  // rotate and round half up
  always_comb begin
    rnd = (PW+1)'(1) <<< (TWIDDLE_BITS - 2);
    if (inv) begin
      pr = PW'(p_rr) + p_ii;
      pi = PW'(p_ir) - p_ri;
    end else begin
      pr = PW'(p_rr) - p_ii;
      pi = PW'(p_ri) + p_ir;
    end
    tr_w = (pr + rnd) >>> (TWIDDLE_BITS - 1);
    ti_w = (pi + rnd) >>> (TWIDDLE_BITS - 1);
    if (bypass) begin
      tr = (BUF_BITS+1)'(br);
      ti = (BUF_BITS+1)'(bi);
    end else begin
      tr = tr_w[BUF_BITS:0];
      ti = ti_w[BUF_BITS:0];
    end
    s_r = (BUF_BITS+2)'(ar) + tr;
    s_i = (BUF_BITS+2)'(ai) + ti;
    d_r = (BUF_BITS+2)'(ar) - tr;
    d_i = (BUF_BITS+2)'(ai) - ti;
    if (inv) begin
      s_r = s_r >>> 1;
      s_i = s_i >>> 1;
      d_r = d_r >>> 1;
      d_i = d_i >>> 1;
    end
    sr = sat_buf(s_r);
    si = sat_buf(s_i);
    dr = sat_buf(d_r);
    di = sat_buf(d_i);
  end

endmodule

FILE: sv/radix2_fft_ifft.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_fft_ifft
// In-place radix-2 DIT FFT / IFFT over a 1024-point store with load, run and
// read commands; one shared butterfly under a small sequencer.
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       input      in_valid, in_ready, func, point_index, sample_real/imag
// out      output     out_valid, out_ready, bin_real, bin_imag, status
// cfg      input      cfg_we, cfg_index, cfg_data
//
// load, read and unknown commands offer their result from S_RESP, after S_RDWAIT;
// no new item is taken until that result has been accepted.
// a run swaps the bit-reversed pairs, then does the butterflies stage by stage,
// then passes through S_RDWAIT and S_RESP to the result.
// reset clears control only; the store holds garbage until loaded.
// a result waits in the output register while out_ready is low.
module radix2_fft_ifft (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [r2fft_pkg::IDX_BITS-1:0] point_index,
  input  logic signed [15:0]            sample_real,
  input  logic signed [15:0]            sample_imag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [25:0]            bin_real,
  output logic signed [25:0]            bin_imag,
  output logic                          status,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [3:0]                    cfg_data
);
  import r2fft_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDWAIT= 4'd1;
  localparam logic [3:0] S_RESP  = 4'd2;
  localparam logic [3:0] S_BR_A  = 4'd3;
  localparam logic [3:0] S_BR_B  = 4'd4;
  localparam logic [3:0] S_BR_W  = 4'd5;
  localparam logic [3:0] S_BR_W2 = 4'd6;
  localparam logic [3:0] S_BF_A  = 4'd7;
  localparam logic [3:0] S_BF_B  = 4'd8;
  localparam logic [3:0] S_BF_M  = 4'd9;
  localparam logic [3:0] S_BF_W  = 4'd10;
  localparam logic [3:0] S_BF_W2 = 4'd11;
  localparam logic [3:0] S_BR_R  = 4'd12;
  localparam logic [3:0] S_BF_R  = 4'd13;
  localparam logic [3:0] S_BF_P  = 4'd14;

  logic [3:0]          state;
  logic [LG_BITS-1:0]  lg;
  logic                inv;
  logic [IDX_BITS:0]   cnt;       // bit-reverse index / butterfly counter
  logic [LG_BITS-1:0]  stage;
  logic [IDX_BITS-1:0] ia, ib;
  logic [IDX_BITS-1:0] tw_idx;
  buf_t                ra_r, ra_i, rb_r, rb_i;
  buf_t                mem_r [MAX_POINTS];
  buf_t                mem_i [MAX_POINTS];
  buf_t                rd_r, rd_i;
  logic                we;
  logic [IDX_BITS-1:0] waddr, raddr;
  buf_t                wdr, wdi;
  logic                is_read;
  logic [2*TWIDDLE_BITS-1:0] tw_q;
  buf_t                sr, si, dr, di;
  logic [IDX_BITS-1:0] nmask;
  logic [IDX_BITS-1:0] rev;
  logic [IDX_BITS-1:0] half, k, base;
  logic                bypass;

  assign nmask = IDX_BITS'((IDX_BITS+1)'(1) << lg) - 1'b1;

  // configuration, size saturated to the maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      lg  <= LG_BITS'(LOG2_MAX_POINTS);
      inv <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SIZE)
        lg <= (cfg_data > LG_BITS'(LOG2_MAX_POINTS)) ? LG_BITS'(LOG2_MAX_POINTS) : cfg_data;
      else
        inv <= cfg_data[0];
    end
  end

  // point store with one write and one read port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdr;
      mem_i[waddr] <= wdi;
    end
    rd_r <= mem_r[raddr];
    rd_i <= mem_i[raddr];
  end

  // bit reversal of the counter within lg bits
  always_comb begin
    rev = '0;
    for (int b = 0; b < IDX_BITS; b++)
      if (b < int'(lg)) rev[int'(lg) - 1 - b] = cnt[b];
  end

  // butterfly addressing from counter and stage
  always_comb begin
    half = IDX_BITS'(1) << stage;
    k    = cnt[IDX_BITS-1:0] & (half - 1'b1);
    base = (cnt[IDX_BITS-1:0] & ~(half - 1'b1)) << 1;
  end

  // twiddle rom, registered
  always_ff @(posedge clk) begin
    tw_q <= TW_ROM[tw_idx[IDX_BITS-2:0]];
  end
  assign bypass = (tw_idx == '0);

  r2fft_bfly u_bfly (
    .clk(clk), .inv(inv), .bypass(bypass),
    .br(rb_r), .bi(rb_i),
    .wr(tw_q[2*TWIDDLE_BITS-1:TWIDDLE_BITS]), .wi(tw_q[TWIDDLE_BITS-1:0]),
    .ar(ra_r), .ai(ra_i),
    .sr(sr), .si(si), .dr(dr), .di(di)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;

  // store port steering
  always_comb begin
    we    = 1'b0;
    waddr = ia;
    raddr = ia;
    wdr   = ra_r;
    wdi   = ra_i;
    case (state)
      S_IDLE: begin
        raddr = point_index;
        waddr = point_index;
        wdr   = BUF_BITS'(sample_real);
        wdi   = BUF_BITS'(sample_imag);
        we    = in_valid && in_ready && func == FUNC_LOAD && (point_index & ~nmask) == '0;
      end
      S_BR_A, S_BF_A: raddr = ia;
      S_BR_B, S_BF_B: raddr = ib;
      S_BR_W:  begin we = 1'b1; waddr = ia; wdr = rd_r; wdi = rd_i; end
      S_BR_W2: begin we = 1'b1; waddr = ib; wdr = ra_r; wdi = ra_i; end
      S_BF_W:  begin we = 1'b1; waddr = ia; wdr = sr; wdi = si; end
      S_BF_W2: begin we = 1'b1; waddr = ib; wdr = rb_r; wdi = rb_i; end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      stage     <= '0;
      is_read   <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          bin_real <= '0;
          bin_imag <= '0;
          status   <= 1'b0;
          is_read  <= 1'b0;
          ia       <= point_index;
          if (func == FUNC_LOAD || func == FUNC_READ) begin
            status  <= (point_index & ~nmask) != '0;
            is_read <= func == FUNC_READ && (point_index & ~nmask) == '0;
            state   <= S_RDWAIT;
          end else if (func == FUNC_RUN) begin
            cnt   <= '0;
            stage <= '0;
            state <= (lg == '0) ? S_RDWAIT : S_BR_R;
          end else
            state <= S_RDWAIT;
        end
        S_RDWAIT: state <= S_RESP;
        S_RESP: begin
          if (is_read) begin
            bin_real <= rd_r;
            bin_imag <= rd_i;
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        // bit reversal: swap entry cnt with rev when rev > cnt
        S_BR_R: begin
          if (cnt[IDX_BITS:0] > (IDX_BITS+1)'(nmask)) begin
            cnt   <= '0;
            state <= S_BF_R;
          end else if (rev > cnt[IDX_BITS-1:0]) begin
            ia    <= cnt[IDX_BITS-1:0];
            ib    <= rev;
            state <= S_BR_A;
          end else
            cnt <= cnt + 1'b1;
        end
        S_BR_A: state <= S_BR_B;
        S_BR_B: begin ra_r <= rd_r; ra_i <= rd_i; state <= S_BR_W; end
        S_BR_W: state <= S_BR_W2;
        S_BR_W2: begin cnt <= cnt + 1'b1; state <= S_BR_R; end
        // butterflies: N/2 per stage
        S_BF_R: begin
          if (cnt[IDX_BITS-1:0] == (nmask >> 1) + 1'b1 || (lg == LG_BITS'(1) && cnt != '0)
              || cnt[IDX_BITS]) begin
            cnt <= '0;
            if (stage == lg - 1'b1) state <= S_RDWAIT;
            else stage <= stage + 1'b1;
          end else begin
            ia     <= base + k;
            ib     <= base + half + k;
            tw_idx <= IDX_BITS'(k << (LG_BITS'(LOG2_MAX_POINTS) - 1'b1 - stage));
            state  <= S_BF_A;
          end
        end
        S_BF_A: state <= S_BF_B;
        S_BF_B: begin ra_r <= rd_r; ra_i <= rd_i; state <= S_BF_M; end
        S_BF_M: begin rb_r <= rd_r; rb_i <= rd_i; state <= S_BF_P; end
        // products of the bottom entry land in the butterfly registers
        S_BF_P: state <= S_BF_W;
        S_BF_W: begin rb_r <= dr; rb_i <= di; state <= S_BF_W2; end
        S_BF_W2: begin cnt <= cnt + 1'b1; state <= S_BF_R; end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
